// File: rtl/gws_pkg.sv
package gws_pkg;

	// Item function codes
	localparam logic [1:0] FUNC_GRID   = 2'd0;
	localparam logic [1:0] FUNC_WORD   = 2'd1;
	localparam logic [1:0] FUNC_PROBE  = 2'd2;
	localparam logic [1:0] FUNC_FINISH = 2'd3;

	// Result kinds
	localparam logic KIND_PROBE  = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	// Direction bits of the match mask
	localparam int DIR_RIGHT = 0;
	localparam int DIR_LEFT  = 1;
	localparam int DIR_DOWN  = 2;
	localparam int DIR_UP    = 3;
	localparam int NUM_DIRS  = 4;

	localparam int           WORD_MAX    = 16;
	localparam logic [4:0]   WORD_LEN_MAX = 5'd16;
	localparam logic [4:0]   SIZE_RESET  = 5'd16;
	localparam logic [10:0]  TOTAL_MAX   = 11'd2047;

	typedef struct packed {
		logic [1:0] func;
		logic [3:0] row;
		logic [3:0] col;
		logic [7:0] char_value;
		logic [3:0] word_index;
		logic [4:0] word_length;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [3:0]  dir_mask;
		logic [10:0] match_total;
		logic        not_found;
	} out_item_t;

	// Classified item handed from the front to the back
	typedef struct packed {
		logic [1:0] func;
		logic [3:0] row;
		logic [3:0] col;
		logic [7:0] char_value;
		logic [3:0] word_index;
		logic [4:0] word_length;
		logic [3:0] dir_en;
		logic       grid_wr;
	} job_t;

	// Queue handshake between front and back
	typedef struct packed {
		logic push;
		logic pop;
	} q_ctrl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// File: rtl/gws_front.sv
module gws_front import gws_pkg::*; #(
	parameter int GRID_MAX = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	input  logic [4:0] cfg_data,
	input  logic       cmd_valid,
	output logic       cmd_stall,
	input  in_item_t   cmd_item,
	input  q_stat_t    q_stat,
	output logic       push,
	output job_t       job
);

	localparam int LIM = (GRID_MAX < 16) ? GRID_MAX : 16;

	logic [4:0] grid_size_q;
	logic [4:0] n;
	logic [4:0] len;
	logic       start_ok;
	logic [3:0] en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q <= SIZE_RESET;
		end else if (cfg_valid) begin
			grid_size_q <= cfg_data;
		end
	end

	always_comb begin
		n   = (grid_size_q > 5'(LIM)) ? 5'(LIM) : grid_size_q;
		len = (cmd_item.word_length > WORD_LEN_MAX) ? WORD_LEN_MAX : cmd_item.word_length;
		start_ok = (len != 5'd0) && ({1'b0, cmd_item.row} < n) && ({1'b0, cmd_item.col} < n);

		en[DIR_RIGHT] = (6'(cmd_item.col) + 6'(len)) <= 6'(n);
		en[DIR_LEFT]  = (6'(cmd_item.col) + 6'd1) >= 6'(len);
		en[DIR_DOWN]  = (6'(cmd_item.row) + 6'(len)) <= 6'(n);
		en[DIR_UP]    = (6'(cmd_item.row) + 6'd1) >= 6'(len);

		job.func        = cmd_item.func;
		job.row         = cmd_item.row;
		job.col         = cmd_item.col;
		job.char_value  = cmd_item.char_value;
		job.word_index  = cmd_item.word_index;
		job.word_length = len;
		job.grid_wr     = (7'(cmd_item.row) < 7'(GRID_MAX)) && (7'(cmd_item.col) < 7'(GRID_MAX));
		case (cmd_item.func)
			FUNC_PROBE: begin
				job.dir_en = start_ok ? en : 4'd0;
			end
			default: begin
				job.dir_en = 4'd0;
			end
		endcase
	end

	assign cmd_stall = q_stat.full;
	assign push      = cmd_valid && !q_stat.full;

endmodule

// File: rtl/gws_fifo.sv
module gws_fifo import gws_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  q_ctrl_t q_ctrl,
	input  job_t    push_data,
	output job_t    pop_data,
	output q_stat_t q_stat
);

	localparam int DEPTH = 2;
	localparam int PW    = $clog2(DEPTH);

	job_t            entry_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (q_ctrl.push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (q_ctrl.pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (q_ctrl.push && !q_ctrl.pop) begin
				cnt_q <= cnt_q + (PW+1)'(1);
			end else if (q_ctrl.pop && !q_ctrl.push) begin
				cnt_q <= cnt_q - (PW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_ctrl.push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	assign pop_data     = entry_q[rd_ptr_q];
	assign q_stat.full  = (cnt_q == (PW+1)'(DEPTH));
	assign q_stat.empty = (cnt_q == '0);

endmodule

// File: rtl/gws_back.sv
module gws_back import gws_pkg::*; #(
	parameter int GRID_MAX = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  q_stat_t   q_stat,
	input  job_t      job,
	output logic      pop,
	output logic      res_valid,
	input  logic      res_stall,
	output out_item_t res_item
);

	localparam int DEPTH = GRID_MAX * GRID_MAX;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t      state_q;
	logic [3:0]  r_q;
	logic [3:0]  c_q;
	logic [4:0]  len_q;
	logic [3:0]  k_q;
	logic [3:0]  match_q;
	logic        kind_q;
	logic [10:0] total_q;
	logic [7:0]  word_q [WORD_MAX];
	logic        cmp_v_s1;
	logic [3:0]  kd_s1;
	logic [7:0]  rd_s1 [NUM_DIRS];
	logic        res_valid_q;
	out_item_t   res_q;

	logic [AW-1:0] wr_addr;
	logic          wr_en;
	logic [AW-1:0] rd_addr [NUM_DIRS];
	logic [3:0]    eq;
	logic          last_k;
	logic          out_free;
	logic [2:0]    hits;
	logic [11:0]   sum;

	function automatic logic [AW-1:0] cell_addr(input logic [3:0] r, input logic [3:0] c);
		return AW'(r) * AW'(GRID_MAX) + AW'(c);
	endfunction

	always_comb begin
		pop      = (state_q == ST_IDLE) && !q_stat.empty;
		wr_en    = pop && (job.func == FUNC_GRID) && job.grid_wr;
		wr_addr  = cell_addr(job.row, job.col);
		rd_addr[DIR_RIGHT] = cell_addr(r_q, c_q + k_q);
		rd_addr[DIR_LEFT]  = cell_addr(r_q, c_q - k_q);
		rd_addr[DIR_DOWN]  = cell_addr(r_q + k_q, c_q);
		rd_addr[DIR_UP]    = cell_addr(r_q - k_q, c_q);
		for (int d = 0; d < NUM_DIRS; d++) begin
			eq[d] = (rd_s1[d] == word_q[kd_s1]);
		end
		last_k   = ({1'b0, k_q} == (len_q - 5'd1));
		out_free = !res_valid_q || !res_stall;
		hits     = 3'(match_q[0]) + 3'(match_q[1]) + 3'(match_q[2]) + 3'(match_q[3]);
		sum      = {1'b0, total_q} + 12'(hits);
	end

	// One grid copy per direction: each bank serves one read address a cycle
	for (genvar d = 0; d < NUM_DIRS; d++) begin : g_bank
		logic [7:0] mem_q [DEPTH];
		always_ff @(posedge clk) begin
			if (wr_en) begin
				mem_q[wr_addr] <= job.char_value;
			end
			rd_s1[d] <= mem_q[rd_addr[d]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			total_q     <= '0;
			cmp_v_s1    <= 1'b0;
		end else begin
			cmp_v_s1 <= (state_q == ST_SCAN);
			if ((state_q == ST_EMIT) && out_free) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						case (job.func)
							FUNC_PROBE: begin
								state_q <= (job.dir_en != 4'd0) ? ST_SCAN : ST_EMIT;
							end
							FUNC_FINISH: begin
								state_q <= ST_EMIT;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (last_k) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (kind_q == KIND_FINISH) begin
							total_q <= '0;
						end else begin
							total_q <= (sum > 12'(TOTAL_MAX)) ? TOTAL_MAX : sum[10:0];
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		kd_s1 <= k_q;
		if (pop) begin
			r_q     <= job.row;
			c_q     <= job.col;
			len_q   <= job.word_length;
			k_q     <= '0;
			match_q <= job.dir_en;
			kind_q  <= (job.func == FUNC_FINISH);
			if (job.func == FUNC_WORD) begin
				word_q[job.word_index] <= job.char_value;
			end
		end else begin
			if (state_q == ST_SCAN) begin
				k_q <= k_q + 4'd1;
			end
			if (cmp_v_s1) begin
				match_q <= match_q & eq;
			end
		end
		if ((state_q == ST_EMIT) && out_free) begin
			res_q.kind <= kind_q;
			if (kind_q == KIND_FINISH) begin
				res_q.dir_mask    <= 4'd0;
				res_q.match_total <= total_q;
				res_q.not_found   <= (total_q == '0);
			end else begin
				res_q.dir_mask    <= match_q;
				res_q.match_total <= '0;
				res_q.not_found   <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

endmodule

// File: rtl/grid_word_search.sv
// A probe is scanned over its saturated word length, then passes drain and emit into the
// result register; a finish, or a probe with no fitting direction, goes straight to emit.
// Grid and word writes are registered when the back takes the item; a stalled result holds
// emit, and no new item is taken while a probe is in flight. The scan compares one word
// position per cycle in all four directions against four grid copies. Writes retire one
// per cycle when idle. Reset (arst_n low) clears control and total, grid_size = 16.
module grid_word_search import gws_pkg::*; #(
	parameter int GRID_MAX = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [4:0] cfg_data,
	input  logic       cmd_valid,
	output logic       cmd_stall,
	input  in_item_t   cmd_item,
	output logic       res_valid,
	input  logic       res_stall,
	output out_item_t  res_item
);

	q_ctrl_t q_ctrl;
	q_stat_t q_stat;
	job_t    push_job;
	job_t    pop_job;

	// The user must change the size register only while the block is idle (unchecked); always ready
	assign cfg_ready = 1'b1;

	// Front: hold the grid size, saturate the word length, work out which of the four
	// directions fit inside the grid, and push the classified item into the queue.
	gws_front #(
		.GRID_MAX (GRID_MAX)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_item  (cmd_item),
		.q_stat    (q_stat),
		.push      (q_ctrl.push),
		.job       (push_job)
	);

	// Short queue: lets new items land while the back is scanning or the result is stalled
	gws_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_ctrl    (q_ctrl),
		.push_data (push_job),
		.pop_data  (pop_job),
		.q_stat    (q_stat)
	);

	// Back: write the stores, scan probes one word position per cycle, keep the running
	// total and drive the registered result slot.
	gws_back #(
		.GRID_MAX (GRID_MAX)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.job       (pop_job),
		.pop       (q_ctrl.pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

endmodule

// File: rtl/gws_checker.sv
module gws_checker import gws_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_valid,
	input logic       cfg_ready,
	input logic [4:0] cfg_data,
	input logic       cmd_valid,
	input logic       cmd_stall,
	input in_item_t   cmd_item,
	input logic       res_valid,
	input logic       res_stall,
	input out_item_t  res_item
);

	// Hold a stalled result
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_item))
		else $error("stalled result changed");

	// A probe result carries no total and no not-found flag
	a_probe_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_item.kind == KIND_PROBE) |->
		(res_item.match_total == 11'd0) && !res_item.not_found)
		else $error("probe result carries summary fields");

	// A finish summary flags not-found exactly when the total is zero
	a_finish_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_item.kind == KIND_FINISH) |->
		(res_item.dir_mask == 4'd0) &&
		(res_item.not_found == (res_item.match_total == 11'd0)))
		else $error("finish summary inconsistent");

endmodule

bind grid_word_search gws_checker u_gws_checker (.*);
